>>> rtl/core/assert_macros.svh
// Assertion macros shared by the lap timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_SYNC(lbl, !(cond), msg)

`endif

>>> rtl/core/rplt_pkg.sv
// Types and constants of the RSSI peak lap timer.
package rplt_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Event codes of a result word.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_BEEP   = 3'd1;
  localparam logic [2:0] EV_START  = 3'd2;
  localparam logic [2:0] EV_LAP    = 3'd3;
  localparam logic [2:0] EV_FINISH = 3'd4;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_RSSI = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_RSSI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAP_MS = 2'd2;

  // Countdown timing in milliseconds.
  localparam logic [31:0] COUNTDOWN_MS = 32'd3000;
  localparam logic [31:0] BEEP_STEP_MS = 32'd1000;

  // Fields of one result word.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [1:0]  countdown_value;
    logic [3:0]  lap_number;
    logic [31:0] lap_time_ms;
    logic [1:0]  race_status;
    logic        lap_ready;
    logic [7:0]  rssi_echo;
  } result_t;

  // Requests from the controller to the lap ring.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } ring_ctl_t;

endpackage

>>> rtl/core/rplt_ring.sv
// Lap ring memory with per-entry valid bits and a registered read port.
module rplt_ring #(
  parameter int LAP_HISTORY = 16,
  parameter int IDX_W = $clog2(LAP_HISTORY)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rplt_pkg::ring_ctl_t ctl,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [31:0]        wdata,
  input  logic [IDX_W-1:0]   raddr,
  output logic [31:0]        rdata
);

  logic [31:0]            mem [LAP_HISTORY];
  logic [LAP_HISTORY-1:0] valid_r;
  logic [31:0]            rd_data_r;
  logic                   rd_vld_r;

  // Storage array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  // Valid bits; a stop clears the whole ring at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[waddr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= valid_r[raddr];
      end
    end
  end

  // An entry never written since the last clear reads as zero.
  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

>>> rtl/core/rplt_ctrl.sv
// Race controller: countdown, peak tracking, lap closing and configuration.
`include "assert_macros.svh"

module rplt_ctrl #(
  parameter int LAP_HISTORY = 16,
  parameter int IDX_W = $clog2(LAP_HISTORY)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rplt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rplt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_fire,
  input  logic [1:0]                     command,
  input  logic [7:0]                     rssi_sample,
  input  logic [31:0]                    time_ms,
  output rplt_pkg::result_t              res,
  output rplt_pkg::ring_ctl_t            ring_ctl,
  output logic [IDX_W-1:0]               ring_waddr,
  output logic [31:0]                    ring_wdata,
  output logic [IDX_W-1:0]               ring_raddr
);

  typedef enum logic [1:0] {
    ST_STOPPED   = 2'd0,
    ST_COUNTDOWN = 2'd1,
    ST_RUNNING   = 2'd2
  } mode_t;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(LAP_HISTORY - 1);

  // Configuration registers.
  logic [7:0]  enter_rssi_r;
  logic [7:0]  exit_rssi_r;
  logic [19:0] min_lap_ms_r;

  // Race state.
  mode_t            mode_r, mode_nxt;
  logic [31:0]      cd_begin_r, cd_begin_nxt;
  logic [1:0]       beeps_left_r, beeps_left_nxt;
  logic [31:0]      race_begin_r, race_begin_nxt;
  logic [31:0]      lap_begin_r, lap_begin_nxt;
  logic [7:0]       peak_level_r, peak_level_nxt;
  logic [31:0]      peak_time_r, peak_time_nxt;
  logic [IDX_W-1:0] ring_idx_r, ring_idx_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic             unread_r, unread_nxt;
  logic [7:0]       last_rssi_r, last_rssi_nxt;

  logic [31:0]      cd_elapsed;
  logic [31:0]      lap_elapsed;
  logic [31:0]      beep_due;
  logic [31:0]      lap_base;
  logic [31:0]      lap_time;
  logic             lap_close;
  logic [IDX_W-1:0] read_idx;

  // Elapsed times and the lap that would close on this tick.
  assign cd_elapsed  = time_ms - cd_begin_r;
  assign lap_elapsed = time_ms - lap_begin_r;
  assign lap_base    = (ring_idx_r == '0 && !wrapped_r) ? race_begin_r : lap_begin_r;
  assign lap_time    = peak_time_r - lap_base;
  assign lap_close   = (rssi_sample < peak_level_r) && (rssi_sample < exit_rssi_r);
  assign read_idx    = (ring_idx_r == '0) ? LastIdx : ring_idx_r - 1'b1;

  // Time at which the next beep is due, counted from the countdown start.
  always_comb begin
    case (beeps_left_r)
      2'd3:    beep_due = rplt_pkg::BEEP_STEP_MS;
      2'd2:    beep_due = 32'(2 * rplt_pkg::BEEP_STEP_MS);
      default: beep_due = 32'(3 * rplt_pkg::BEEP_STEP_MS);
    endcase
  end

  // Next state and result word for the word at the input.
  always_comb begin
    mode_nxt        = mode_r;
    cd_begin_nxt    = cd_begin_r;
    beeps_left_nxt  = beeps_left_r;
    race_begin_nxt  = race_begin_r;
    lap_begin_nxt   = lap_begin_r;
    peak_level_nxt  = peak_level_r;
    peak_time_nxt   = peak_time_r;
    ring_idx_nxt    = ring_idx_r;
    wrapped_nxt     = wrapped_r;
    unread_nxt      = unread_r;
    last_rssi_nxt   = last_rssi_r;
    res             = '0;
    res.event_res   = rplt_pkg::EV_NONE;
    ring_ctl        = '0;
    ring_waddr      = ring_idx_r;
    ring_wdata      = lap_time;
    ring_raddr      = read_idx;

    unique case (command)
      rplt_pkg::CMD_START: begin
        cd_begin_nxt        = time_ms;
        beeps_left_nxt      = 2'd3;
        mode_nxt            = ST_COUNTDOWN;
        res.event_res       = rplt_pkg::EV_BEEP;
        res.countdown_value = 2'd3;
      end
      rplt_pkg::CMD_STOP: begin
        mode_nxt       = ST_STOPPED;
        wrapped_nxt    = 1'b0;
        ring_idx_nxt   = '0;
        ring_ctl.clear = in_fire;
        res.event_res  = rplt_pkg::EV_FINISH;
      end
      rplt_pkg::CMD_READ: begin
        unread_nxt     = 1'b0;
        ring_ctl.rd_en = in_fire;
        res.lap_number = 4'(read_idx);
      end
      default: begin
        last_rssi_nxt = rssi_sample;
        unique case (mode_r)
          ST_COUNTDOWN: begin
            if (cd_elapsed >= rplt_pkg::COUNTDOWN_MS) begin
              race_begin_nxt = time_ms;
              lap_begin_nxt  = time_ms;
              peak_level_nxt = '0;
              peak_time_nxt  = '0;
              mode_nxt       = ST_RUNNING;
              res.event_res  = rplt_pkg::EV_START;
            end else if (beeps_left_r != 2'd0 && cd_elapsed >= beep_due) begin
              beeps_left_nxt = beeps_left_r - 2'd1;
              if (beeps_left_r != 2'd1) begin
                res.event_res       = rplt_pkg::EV_BEEP;
                res.countdown_value = beeps_left_r - 2'd1;
              end
            end
          end
          ST_RUNNING: begin
            // A new peak can never close the lap on the same tick.
            if (lap_elapsed > {12'd0, min_lap_ms_r} && rssi_sample >= enter_rssi_r &&
                rssi_sample > peak_level_r) begin
              peak_level_nxt = rssi_sample;
              peak_time_nxt  = time_ms;
            end
            if (lap_close) begin
              ring_ctl.wr_en  = in_fire;
              res.event_res   = rplt_pkg::EV_LAP;
              res.lap_number  = 4'(ring_idx_r);
              res.lap_time_ms = lap_time;
              if (ring_idx_r == LastIdx) begin
                wrapped_nxt  = 1'b1;
                ring_idx_nxt = '0;
              end else begin
                ring_idx_nxt = ring_idx_r + 1'b1;
              end
              unread_nxt     = 1'b1;
              lap_begin_nxt  = peak_time_r;
              peak_level_nxt = '0;
              peak_time_nxt  = '0;
            end
          end
          default: begin
          end
        endcase
      end
    endcase

    res.race_status = mode_nxt;
    res.lap_ready   = unread_nxt;
    res.rssi_echo   = last_rssi_nxt;
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_rssi_r <= 8'd120;
      exit_rssi_r  <= 8'd100;
      min_lap_ms_r <= 20'd5000;
      mode_r       <= ST_STOPPED;
      cd_begin_r   <= '0;
      beeps_left_r <= '0;
      race_begin_r <= '0;
      lap_begin_r  <= '0;
      peak_level_r <= '0;
      peak_time_r  <= '0;
      ring_idx_r   <= '0;
      wrapped_r    <= 1'b0;
      unread_r     <= 1'b0;
      last_rssi_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rplt_pkg::CFG_ENTER_RSSI: enter_rssi_r <= cfg_wdata[7:0];
          rplt_pkg::CFG_EXIT_RSSI:  exit_rssi_r  <= cfg_wdata[7:0];
          rplt_pkg::CFG_MIN_LAP_MS: min_lap_ms_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        mode_r       <= mode_nxt;
        cd_begin_r   <= cd_begin_nxt;
        beeps_left_r <= beeps_left_nxt;
        race_begin_r <= race_begin_nxt;
        lap_begin_r  <= lap_begin_nxt;
        peak_level_r <= peak_level_nxt;
        peak_time_r  <= peak_time_nxt;
        ring_idx_r   <= ring_idx_nxt;
        wrapped_r    <= wrapped_nxt;
        unread_r     <= unread_nxt;
        last_rssi_r  <= last_rssi_nxt;
      end
    end
  end

  // A lap write and a ring clear come from different commands.
  `ASSERT_NEVER(a_wr_clear, ring_ctl.wr_en && ring_ctl.clear, "lap write during ring clear")
  // A recorded lap is flagged unread afterwards.
  `ASSERT_SYNC(a_lap_unread, ring_ctl.wr_en |=> unread_r, "lap written but not flagged unread")
  // The ring index stays inside the ring.
  `ASSERT_SYNC(a_idx_range, ring_idx_r <= LastIdx, "ring index beyond ring depth")

endmodule

>>> rtl/core/rssi_peak_lap_timer.sv
// RSSI peak lap timer top level: handshakes, controller, lap ring, result register.
//
// Input words (in_command, in_rssi_sample, in_time_ms) are taken on in_valid and
// in_ready; every word yields exactly one result word on the out_ channel.
// Commands: tick with sample, start countdown, stop, read last lap.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set enter_rssi (0),
// exit_rssi (1) and min_lap_ms (2); write them only while the block is idle.
// A word accepted at one edge shows its result from the next cycle on.
// Throughput is one word per cycle while results are taken; all race state is updated in
// the cycle of acceptance and the lap ring read of a read command is registered
// in the ring's read port at the same edge as the result word.
// The result register holds a word until out_ready; a new word is accepted in
// the same cycle the held result is taken, so the block stalls only while the
// result waits and out_ready is low.
// Reset (rst_n low, synchronous) stops the race, loads the default thresholds,
// clears the unread flag and marks every lap ring entry as zero at once.
`include "assert_macros.svh"

module rssi_peak_lap_timer #(
  parameter int LAP_HISTORY = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rplt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rplt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic [7:0]                      in_rssi_sample,
  input  logic [31:0]                     in_time_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_event_res,
  output logic [1:0]                      out_countdown_value,
  output logic [3:0]                      out_lap_number,
  output logic [31:0]                     out_lap_time_ms,
  output logic [1:0]                      out_race_status,
  output logic                            out_lap_ready,
  output logic [7:0]                      out_rssi_echo
);

  localparam int IdxW = $clog2(LAP_HISTORY);

  logic                in_fire;
  rplt_pkg::result_t   ctrl_res;
  rplt_pkg::ring_ctl_t ring_ctl;
  logic [IdxW-1:0]     ring_waddr;
  logic [IdxW-1:0]     ring_raddr;
  logic [31:0]         ring_wdata;
  logic [31:0]         ring_rdata;
  rplt_pkg::result_t   res_r;
  logic                rd_sel_r;
  logic                out_valid_r;

  // Accept whenever the result register is free or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  rplt_ctrl #(
    .LAP_HISTORY (LAP_HISTORY),
    .IDX_W       (IdxW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_fire     (in_fire),
    .command     (in_command),
    .rssi_sample (in_rssi_sample),
    .time_ms     (in_time_ms),
    .res         (ctrl_res),
    .ring_ctl    (ring_ctl),
    .ring_waddr  (ring_waddr),
    .ring_wdata  (ring_wdata),
    .ring_raddr  (ring_raddr)
  );

  rplt_ring #(
    .LAP_HISTORY (LAP_HISTORY),
    .IDX_W       (IdxW)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; a read takes its lap time from the ring port.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r    <= ctrl_res;
      rd_sel_r <= ring_ctl.rd_en;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = res_r.event_res;
  assign out_countdown_value = res_r.countdown_value;
  assign out_lap_number      = res_r.lap_number;
  assign out_lap_time_ms     = rd_sel_r ? ring_rdata : res_r.lap_time_ms;
  assign out_race_status     = res_r.race_status;
  assign out_lap_ready       = res_r.lap_ready;
  assign out_rssi_echo       = res_r.rssi_echo;

  // A ring read is always followed by a result that selects the ring data.
  `ASSERT_SYNC(a_read_result, ring_ctl.rd_en |=> out_valid_r && rd_sel_r, "ring read lost")

endmodule

>>> verif/lap_result_checker.sv
`timescale 1ns / 100ps
// Checker for the lap timer: mirrors race state, predicts every result word and compares.
module lap_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rplt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rplt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic [7:0]                      in_rssi_sample,
  input  logic [31:0]                     in_time_ms,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [2:0]                      out_event_res,
  input  logic [1:0]                      out_countdown_value,
  input  logic [3:0]                      out_lap_number,
  input  logic [31:0]                     out_lap_time_ms,
  input  logic [1:0]                      out_race_status,
  input  logic                            out_lap_ready,
  input  logic [7:0]                      out_rssi_echo,
  output int                              mismatches,
  output int                              words_owed,
  output int                              laps_closed
);

  localparam int RING_DEPTH = 16;

  typedef enum logic [1:0] {
    RACE_STOPPED   = 2'd0,
    RACE_COUNTDOWN = 2'd1,
    RACE_RUNNING   = 2'd2
  } race_mode_t;

  // Mirrored thresholds.
  logic [7:0]  enter_level;
  logic [7:0]  exit_level;
  logic [19:0] min_lap;

  // Mirrored race state.
  race_mode_t  mode;
  logic [31:0] countdown_t0;
  logic [1:0]  beeps;
  logic [31:0] race_t0;
  logic [31:0] lap_t0;
  logic [7:0]  peak_lvl;
  logic [31:0] peak_t;
  logic [31:0] lap_ring [RING_DEPTH];
  logic [3:0]  ring_wr;
  logic        ring_full;
  logic        unread;
  logic [7:0]  last_sample;

  rplt_pkg::result_t pending_results [$];
  int errors = 0;
  int laps = 0;

  // Advances the mirrored race by one input word and returns the result word it gives.
  function automatic rplt_pkg::result_t step_race(input logic [1:0] cmd,
                                                  input logic [7:0] sample,
                                                  input logic [31:0] now);
    rplt_pkg::result_t r;
    logic [31:0] elapsed;
    logic [31:0] since_lap;
    logic [31:0] lap_ms;
    logic [3:0]  slot;
    r = '0;
    case (cmd)
      rplt_pkg::CMD_START: begin
        countdown_t0 = now;
        beeps = 2'd3;
        mode = RACE_COUNTDOWN;
        r.event_res = rplt_pkg::EV_BEEP;
        r.countdown_value = 2'd3;
      end
      rplt_pkg::CMD_STOP: begin
        mode = RACE_STOPPED;
        ring_full = 1'b0;
        ring_wr = '0;
        for (int i = 0; i < RING_DEPTH; i++) lap_ring[i] = '0;
        r.event_res = rplt_pkg::EV_FINISH;
      end
      rplt_pkg::CMD_READ: begin
        // The entry just before the write slot, wrapping to the top of the ring.
        slot = ring_wr - 4'd1;
        unread = 1'b0;
        r.lap_number = slot;
        r.lap_time_ms = lap_ring[slot];
      end
      default: begin
        last_sample = sample;
        if (mode == RACE_COUNTDOWN) begin
          elapsed = now - countdown_t0;
          if (elapsed >= rplt_pkg::COUNTDOWN_MS) begin
            race_t0 = now;
            mode = RACE_RUNNING;
            lap_t0 = now;
            peak_lvl = '0;
            peak_t = '0;
            r.event_res = rplt_pkg::EV_START;
          end else if (beeps != 2'd0 &&
                       elapsed >= (32'd4 - 32'(beeps)) * rplt_pkg::BEEP_STEP_MS) begin
            beeps = beeps - 2'd1;
            if (beeps != 2'd0) begin
              r.event_res = rplt_pkg::EV_BEEP;
              r.countdown_value = beeps;
            end
          end
        end else if (mode == RACE_RUNNING) begin
          // Peak tracking opens only once the minimum lap time has passed.
          since_lap = now - lap_t0;
          if (since_lap > 32'(min_lap) && sample >= enter_level && sample > peak_lvl) begin
            peak_lvl = sample;
            peak_t = now;
          end
          // A sample under both the peak and the exit level closes the lap.
          if (sample < peak_lvl && sample < exit_level) begin
            slot = ring_wr;
            if (slot == 4'd0 && !ring_full) lap_ms = peak_t - race_t0;
            else lap_ms = peak_t - lap_t0;
            lap_ring[slot] = lap_ms;
            r.event_res = rplt_pkg::EV_LAP;
            r.lap_number = slot;
            r.lap_time_ms = lap_ms;
            if (slot == 4'(RING_DEPTH - 1)) ring_full = 1'b1;
            ring_wr = slot + 4'd1;
            unread = 1'b1;
            lap_t0 = peak_t;
            peak_lvl = '0;
            peak_t = '0;
          end
        end
      end
    endcase
    r.race_status = mode;
    r.lap_ready = unread;
    r.rssi_echo = last_sample;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Result words are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin : watch
    rplt_pkg::result_t want;
    if (!rst_n) begin
      enter_level = 8'd120;
      exit_level = 8'd100;
      min_lap = 20'd5000;
      mode = RACE_STOPPED;
      countdown_t0 = '0;
      beeps = '0;
      race_t0 = '0;
      lap_t0 = '0;
      peak_lvl = '0;
      peak_t = '0;
      for (int i = 0; i < RING_DEPTH; i++) lap_ring[i] = '0;
      ring_wr = '0;
      ring_full = 1'b0;
      unread = 1'b0;
      last_sample = '0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result word with none expected, expected nothing, actual event %0d",
                   $time, out_event_res);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_res", want.event_res, out_event_res);
          check_field("countdown_value", want.countdown_value, out_countdown_value);
          check_field("lap_number", want.lap_number, out_lap_number);
          check_field("lap_time_ms", want.lap_time_ms, out_lap_time_ms);
          check_field("race_status", want.race_status, out_race_status);
          check_field("lap_ready", want.lap_ready, out_lap_ready);
          check_field("rssi_echo", want.rssi_echo, out_rssi_echo);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          rplt_pkg::CFG_ENTER_RSSI: enter_level = cfg_wdata[7:0];
          rplt_pkg::CFG_EXIT_RSSI:  exit_level = cfg_wdata[7:0];
          rplt_pkg::CFG_MIN_LAP_MS: min_lap = cfg_wdata[19:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = step_race(in_command, in_rssi_sample, in_time_ms);
        pending_results.push_back(want);
        if (want.event_res == rplt_pkg::EV_LAP) laps++;
      end
    end
    mismatches <= errors;
    words_owed <= pending_results.size();
    laps_closed <= laps;
  end

endmodule

>>> verif/rssi_peak_lap_timer_test.sv
`timescale 1ns / 100ps
// Top of the lap timer testbench: clock, reset, stimulus, pacing and the verdict.
module rssi_peak_lap_timer_test;

  localparam int STALL_LIMIT = 1000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [rplt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rplt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      in_command = rplt_pkg::CMD_TICK;
  logic [7:0]                      in_rssi_sample = '0;
  logic [31:0]                     in_time_ms = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [2:0]                      out_event_res;
  logic [1:0]                      out_countdown_value;
  logic [3:0]                      out_lap_number;
  logic [31:0]                     out_lap_time_ms;
  logic [1:0]                      out_race_status;
  logic                            out_lap_ready;
  logic [7:0]                      out_rssi_echo;

  int mismatches;
  int words_owed;
  int laps_closed;

  // Stimulus shaping state; the race flag is only a rough guess of what the block does.
  bit          steady = 1'b0;
  bit          racing = 1'b0;
  int          settle_ticks = 0;
  int          words_sent = 0;
  logic [31:0] clock_ms;
  logic [7:0]  enter_v = 8'd120;
  logic [7:0]  exit_v = 8'd100;
  logic [19:0] min_lap_v = 20'd5000;

  rssi_peak_lap_timer DUT (.*);

  lap_result_checker watch (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: long ready stretches broken by random stalls until the steady part.
  initial begin : sink_pace
    int run;
    forever begin
      run = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // Ends the run when nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("rssi_peak_lap_timer_test: errors");
    $finish;
  end

  // Offers one word, with an occasional idle burst first, and returns once it is taken.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] sample,
                           input logic [31:0] stamp);
    if (!steady && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_rssi_sample <= sample;
    in_time_ms <= stamp;
    do begin
      @(posedge clk);
    end while (!in_ready);
    words_sent++;
  endtask

  // Writes one register once every result is back and the block has settled.
  task automatic write_reg(input logic [rplt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rplt_pkg::CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (words_owed != 0);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [7:0] enter_lvl, input logic [7:0] exit_lvl,
                                input logic [19:0] min_ms);
    write_reg(rplt_pkg::CFG_ENTER_RSSI, 20'(enter_lvl));
    write_reg(rplt_pkg::CFG_EXIT_RSSI, 20'(exit_lvl));
    write_reg(rplt_pkg::CFG_MIN_LAP_MS, min_ms);
    enter_v = enter_lvl;
    exit_v = exit_lvl;
    min_lap_v = min_ms;
  endtask

  // Mostly races with gate passes: high samples past the minimum lap time, then low ones.
  // Reads, restarts, stops and time jumps are mixed in as noise.
  task automatic run_phase(input int count);
    int          pick;
    logic [7:0]  sample;
    logic [31:0] step;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (settle_ticks > 0) step = $urandom_range(1, 1100);
      else step = $urandom_range(1, int'(min_lap_v) + 300);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: sample = 8'($urandom_range(int'(enter_v), 255));
        4, 5, 6, 7: sample = (exit_v == 8'd0) ? 8'd0 : 8'($urandom_range(0, int'(exit_v) - 1));
        default: sample = 8'($urandom);
      endcase
      clock_ms = clock_ms + step;
      if (!racing && pick < 25) begin
        send_word(rplt_pkg::CMD_START, 8'($urandom), clock_ms);
        racing = 1'b1;
        settle_ticks = 8;
      end else if (pick < 5) begin
        send_word(rplt_pkg::CMD_READ, 8'($urandom), clock_ms);
      end else if (pick < 6) begin
        send_word(rplt_pkg::CMD_STOP, 8'($urandom), clock_ms);
        racing = 1'b0;
      end else if (pick < 8) begin
        send_word(rplt_pkg::CMD_START, 8'($urandom), clock_ms);
        racing = 1'b1;
        settle_ticks = 8;
      end else if (pick < 11) begin
        clock_ms = $urandom;
        send_word(rplt_pkg::CMD_TICK, 8'($urandom), clock_ms);
      end else begin
        send_word(rplt_pkg::CMD_TICK, sample, clock_ms);
        if (settle_ticks > 0) settle_ticks--;
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Stopped block: tick echoes, read of an empty ring, stop while stopped.
    send_word(rplt_pkg::CMD_TICK, 8'hFF, 32'h0000_0000);
    send_word(rplt_pkg::CMD_READ, 8'hA5, 32'hFFFF_FFFF);
    send_word(rplt_pkg::CMD_STOP, 8'h5A, 32'h8000_0000);

    // Countdown near the time wrap, restarted once, with beeps at their edges.
    t = 32'hFFFF_F000;
    send_word(rplt_pkg::CMD_START, 8'hFF, t);
    t = t + 32'd700;
    send_word(rplt_pkg::CMD_START, 8'h00, t);
    send_word(rplt_pkg::CMD_TICK, 8'h80, t + 32'd999);
    send_word(rplt_pkg::CMD_TICK, 8'h81, t + 32'd1000);
    send_word(rplt_pkg::CMD_TICK, 8'h82, t + 32'd1999);
    send_word(rplt_pkg::CMD_TICK, 8'h83, t + 32'd2000);
    send_word(rplt_pkg::CMD_TICK, 8'h84, t + 32'd2999);
    send_word(rplt_pkg::CMD_TICK, 8'h00, t + 32'd3000);

    // First lap timed from race start; minimum lap time and exit level at their edges.
    t = t + 32'd3000;
    send_word(rplt_pkg::CMD_TICK, 8'd200, t + 32'd5000);
    send_word(rplt_pkg::CMD_TICK, 8'd119, t + 32'd5001);
    send_word(rplt_pkg::CMD_TICK, 8'd200, t + 32'd5002);
    send_word(rplt_pkg::CMD_TICK, 8'd255, t + 32'd6000);
    send_word(rplt_pkg::CMD_TICK, 8'd100, t + 32'd6100);
    send_word(rplt_pkg::CMD_TICK, 8'd99, t + 32'd6200);
    send_word(rplt_pkg::CMD_READ, 8'hFF, t + 32'd6300);

    // Second lap from the previous peak, restart while running, stop clears the ring.
    send_word(rplt_pkg::CMD_TICK, 8'd180, t + 32'd11001);
    send_word(rplt_pkg::CMD_TICK, 8'd0, t + 32'd11002);
    send_word(rplt_pkg::CMD_START, 8'hFF, t + 32'd12000);
    send_word(rplt_pkg::CMD_READ, 8'h00, t + 32'd12001);
    send_word(rplt_pkg::CMD_STOP, 8'hFF, t + 32'd12002);
    send_word(rplt_pkg::CMD_READ, 8'hFF, t + 32'd12003);

    // Random races under several threshold settings, the extremes first.
    clock_ms = $urandom;
    racing = 1'b0;
    set_thresholds(8'd0, 8'd0, 20'd0);
    run_phase(60);
    set_thresholds(8'd255, 8'd255, 20'hFFFFF);
    run_phase(90);
    set_thresholds(8'd200, 8'd50, 20'd1500);
    run_phase(90);
    set_thresholds(8'd0, 8'd255, 20'd0);
    run_phase(90);
    set_thresholds(8'($urandom_range(100, 220)), 8'($urandom_range(20, 100)),
                   20'($urandom_range(0, 4000)));
    run_phase(100);
    set_thresholds(8'($urandom_range(60, 255)), 8'($urandom_range(0, 60)),
                   20'($urandom_range(0, 3000)));
    steady = 1'b1;
    run_phase(100);

    // Drain the result side before the verdict.
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (words_owed != 0);
    repeat (4) @(posedge clk);

    $display("Run covered %0d words under the reset and six written threshold settings.",
             words_sent);
    $display("Predicted %0d closed laps, with countdowns, restarts, stops and reads mixed in.",
             laps_closed);
    if (mismatches == 0 && words_owed == 0) begin
      $display("rssi_peak_lap_timer_test: clean");
    end else begin
      $display("rssi_peak_lap_timer_test: errors");
    end
    $finish;
  end

endmodule
